>>> hdl/csalu_pkg.sv
// ----------------------------------------------------------------------------
// csalu_pkg
// Shared types and constants for the checked signed ALU.
// ----------------------------------------------------------------------------
package csalu_pkg;

	localparam int DW      = 32;
	localparam int FW      = 32;
	localparam int STEPS   = 4;
	localparam int NCH     = (DW + STEPS - 1) / STEPS;
	localparam int LST     = NCH + 3;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIV0 = 2'd2
	} status_t;

	typedef struct packed {
		logic            vld;
		op_t             op;
		logic            neg;
		logic [DW-1:0]   a;
		logic [DW-1:0]   b;
		logic [DW-1:0]   res;
		status_t         st;
		logic [DW-1:0]   rem;
		logic [DW-1:0]   quo;
		logic [DW-1:0]   dvs;
		logic [2*DW-1:0] prod;
	} stage_t;

endpackage

>>> hdl/checked_signed_alu.sv
// ----------------------------------------------------------------------------
// checked_signed_alu
// Pipelined signed add, subtract, multiply and divide with overflow status.
// ----------------------------------------------------------------------------
// One transaction is accepted per clock while the output is not stalled, and
// every transaction gives one result. Each transaction passes through LST
// register stages (11 at 32 bits) and its result is presented from the last
// of them. The stages are one input stage, one operand stage, a chain of
// divider stages that each settle four quotient bits, and one output stage.
// Every operation passes through the divider chain, so results leave in
// order. A stall on the output side freezes the whole pipeline.
module checked_signed_alu (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [63:0]          s_tdata,   // operand_a[31:0], operand_b[63:32]
	input  logic [1:0]           s_tuser,   // req_type[1:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata,   // result_value[31:0]
	output logic [1:0]           m_tuser    // status[1:0]
);
	import csalu_pkg::*;

	stage_t pl_s [1:LST];
	stage_t nx   [2:LST];
	logic   adv;

	function automatic logic [2*DW-1:0] div_chunk(input logic [DW-1:0] rem,
			input logic [DW-1:0] quo, input logic [DW-1:0] dvs, input int c);
		logic [DW:0]   r;
		logic [DW-1:0] q;
		r = {1'b0, rem};
		q = quo;
		for (int j = 0; j < STEPS; j++) begin
			if (c * STEPS + j < DW) begin
				r = {r[DW-1:0], q[DW-1]};
				q = {q[DW-2:0], 1'b0};
				if (r >= {1'b0, dvs}) begin
					r    = r - {1'b0, dvs};
					q[0] = 1'b1;
				end
			end
		end
		return {r[DW-1:0], q};
	endfunction

	assign adv      = !pl_s[LST].vld || m_tready;
	assign s_tready = adv;
	assign m_tvalid = pl_s[LST].vld;
	assign m_tdata  = FW'($signed(pl_s[LST].res));
	assign m_tuser  = pl_s[LST].st;

	always_comb begin
		logic [DW-1:0]   sa;
		logic [DW-1:0]   sb;
		logic [DW-1:0]   lim;
		logic [DW-1:0]   pl;
		logic [2*DW-1:0] dc;
		sa  = '0;
		sb  = '0;
		lim = '0;
		pl  = '0;
		dc  = '0;
		for (int k = 2; k <= LST; k++) begin
			nx[k] = pl_s[k-1];
			if (k == 2) begin
				sa = pl_s[1].a;
				sb = pl_s[1].b;
				nx[k].neg = sa[DW-1] ^ sb[DW-1];
				nx[k].quo = sa[DW-1] ? (~sa + 1'b1) : sa;
				nx[k].dvs = sb[DW-1] ? (~sb + 1'b1) : sb;
				nx[k].rem = '0;
				nx[k].st  = ST_OK;
				nx[k].res = '0;
				if (pl_s[1].op == OP_ADD) begin
					nx[k].res = sa + sb;
					if (sa[DW-1] == sb[DW-1] && nx[k].res[DW-1] != sa[DW-1])
						nx[k].st = ST_OVF;
				end else if (pl_s[1].op == OP_SUB) begin
					nx[k].res = sa - sb;
					if (sa[DW-1] != sb[DW-1] && nx[k].res[DW-1] != sa[DW-1])
						nx[k].st = ST_OVF;
				end
			end
			if (k == 3)
				nx[k].prod = pl_s[k-1].quo * pl_s[k-1].dvs;
			if (k == 4 && pl_s[k-1].op == OP_MUL) begin
				lim = {1'b1, {(DW-1){1'b0}}} - {{(DW-1){1'b0}}, !pl_s[k-1].neg};
				pl  = pl_s[k-1].prod[DW-1:0];
				nx[k].res = pl_s[k-1].neg ? (~pl + 1'b1) : pl;
				nx[k].st  = (pl_s[k-1].prod[2*DW-1:DW] != '0 || pl > lim) ? ST_OVF : ST_OK;
			end
			if (k >= 3 && k <= NCH + 2) begin
				dc = div_chunk(pl_s[k-1].rem, pl_s[k-1].quo, pl_s[k-1].dvs, k - 3);
				nx[k].rem = dc[2*DW-1:DW];
				nx[k].quo = dc[DW-1:0];
			end
			if (k == LST && pl_s[k-1].op == OP_DIV) begin
				if (pl_s[k-1].dvs == '0) begin
					nx[k].res = '0;
					nx[k].st  = ST_DIV0;
				end else begin
					nx[k].res = pl_s[k-1].neg ? (~pl_s[k-1].quo + 1'b1) : pl_s[k-1].quo;
					nx[k].st  = (!pl_s[k-1].neg && pl_s[k-1].quo[DW-1]) ? ST_OVF : ST_OK;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LST; k++)
				pl_s[k].vld <= 1'b0;
		end else if (adv) begin
			pl_s[1].vld  <= s_tvalid;
			pl_s[1].op   <= op_t'(s_tuser);
			pl_s[1].neg  <= 1'b0;
			pl_s[1].a    <= DW'($signed(s_tdata[31:0]));
			pl_s[1].b    <= DW'($signed(s_tdata[63:32]));
			pl_s[1].res  <= '0;
			pl_s[1].st   <= ST_OK;
			pl_s[1].rem  <= '0;
			pl_s[1].quo  <= '0;
			pl_s[1].dvs  <= '0;
			pl_s[1].prod <= '0;
			for (int k = 2; k <= LST; k++)
				pl_s[k] <= nx[k];
		end
	end

endmodule

>>> hdl/csalu_chk.sv
// ----------------------------------------------------------------------------
// csalu_chk
// Port-level checks for the checked signed ALU, bound to the top level.
// ----------------------------------------------------------------------------
module csalu_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import csalu_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser == ST_OK || m_tuser == ST_OVF || m_tuser == ST_DIV0)
		else $error("undefined status code");

	a_div0: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_DIV0 |-> m_tdata == '0)
		else $error("divide by zero result not zero");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output stall");

endmodule

bind checked_signed_alu csalu_chk u_csalu_chk (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready), .m_tvalid(m_tvalid),
	.m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

>>> test/alu_checker.sv
// ----------------------------------------------------------------------------
// alu_checker
// Watches both stream channels of the checked signed ALU, predicts the result
// and status of every accepted request and compares them in order.
// ----------------------------------------------------------------------------
module alu_checker
	import csalu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [31:0] value;
		status_t     st;
	} alu_result_t;

	alu_result_t expected_results[$];

	function automatic alu_result_t compute_result(op_t op, logic [31:0] a, logic [31:0] b);
		alu_result_t r;
		logic signed [65:0] exact;
		logic signed [65:0] sa;
		logic signed [65:0] sb;
		sa = $signed(a);
		sb = $signed(b);
		r.st = ST_OK;
		case (op)
			OP_ADD: exact = sa + sb;
			OP_SUB: exact = sa - sb;
			OP_MUL: exact = sa * sb;
			default: begin
				if (b == 32'd0)
					exact = 0;
				else
					exact = sa / sb;
			end
		endcase
		r.value = exact[31:0];
		if (op == OP_DIV && b == 32'd0)
			r.st = ST_DIV0;
		else if (exact > 66'sd2147483647 || exact < -66'sd2147483648)
			r.st = ST_OVF;
		return r;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		alu_result_t exp_r;
		if (!arst_n) begin
			errors <= 0;
			expected_results.delete();
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(compute_result(op_t'(s_tuser), s_tdata[31:0],
					s_tdata[63:32]));
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result value %h status %0d", $time, m_tdata,
						m_tuser);
					errors <= errors + 1;
				end else begin
					exp_r = expected_results.pop_front();
					if (m_tdata !== exp_r.value || m_tuser !== exp_r.st) begin
						$display("%0t: expected value %h status %0d, actual value %h status %0d",
							$time, exp_r.value, exp_r.st, m_tdata, m_tuser);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives directed corner cases and random requests into the checked signed ALU
// with bursty input and a stalling output, and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import csalu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	int          errors;
	int          pending;
	logic        stall_run = 1'b1;

	checked_signed_alu dut (.*);
	alu_checker checker_i (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

	// The receiver alternates stall-free stretches with random back pressure.
	always @(posedge clk) begin
		if ($urandom_range(0, 63) == 0)
			stall_run <= ~stall_run;
		m_tready <= stall_run ? 1'b1 : ($urandom_range(0, 2) != 0);
	end

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'd0;
			4: return $urandom_range(0, 15) - 8;
			5: return $urandom_range(0, 131071) - 65536;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_request(op_t op, logic [31:0] a, logic [31:0] b);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {b, a};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic idle_gap();
		int n;
		n = $urandom_range(1, 5);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	initial begin
		logic [31:0] corners[6];
		int left;
		int burst;
		int waited;
		corners = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'd0, 32'd1, 32'h8000_0001};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int op = 0; op < 4; op++) begin
			send_request(op_t'(op), corners[0], corners[2]);
			send_request(op_t'(op), corners[1], corners[1]);
			send_request(op_t'(op), corners[0], corners[0]);
			send_request(op_t'(op), corners[1], corners[3]);
			send_request(op_t'(op), corners[5], corners[2]);
		end
		send_request(OP_MUL, 32'h0001_0000, 32'h0000_8000);
		send_request(OP_MUL, 32'hffff_0000, 32'h0000_8000);
		send_request(OP_DIV, 32'hffff_fff9, 32'd2);
		send_request(OP_DIV, 32'd7, 32'hffff_fffe);
		left = 950;
		while (left > 0) begin
			if ($urandom_range(0, 2) == 0)
				idle_gap();
			burst = $urandom_range(1, 40);
			while (burst > 0 && left > 0) begin
				send_request(op_t'($urandom_range(0, 3)), pick_operand(), pick_operand());
				burst--;
				left--;
			end
		end
		s_tvalid <= 1'b0;
		waited = 0;
		while (pending != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (2 * LST) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
